// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pge_pkg.sv
package pge_pkg;

  localparam logic [2:0] REG_STRENGTH = 3'd0;
  localparam logic [2:0] REG_RADIUS   = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_REST     = 3'd4;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;
  localparam logic [31:0] MAG_MAX = 32'h7fff_ffff;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LOAD, ACT_D2_SET, ACT_D2_ADD, ACT_SPD_SET, ACT_SPD_ADD,
    ACT_SQ_INIT, ACT_SQ_STEP, ACT_DV_INIT, ACT_DV_STEP, ACT_LD_INIT,
    ACT_LD_STEP, ACT_ACC_SAVE, ACT_VX_UPD, ACT_VY_UPD, ACT_PX_UPD,
    ACT_PY_UPD, ACT_COMMIT
  } act_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_MX2, MUL_MY2, MUL_VX2, MUL_VY2, MUL_DIR_STR,
    MUL_AX_DT, MUL_AY_DT, MUL_VX_DT, MUL_VY_DT
  } mul_sel_t;

  typedef struct packed {
    act_t     act;
    mul_sel_t msel;
    logic     axis;   // 0 works on x, 1 on y
  } cmd_t;

  typedef struct packed {
    logic d2_zero;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = SAT_HI[31:0];
    else if (v < SAT_LO) r = SAT_LO[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [39:0] with_sign(input logic [31:0] m, input logic neg);
    logic signed [39:0] e;
    e = $signed({8'd0, m});
    return neg ? -e : e;
  endfunction

endpackage

// File: design/pge_in_if.sv
interface pge_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] attractor_x;
  logic signed [31:0] attractor_y;
  logic [15:0]        time_step;

  modport source (output valid, attractor_x, attractor_y, time_step, input ready);
  modport sink (input valid, attractor_x, attractor_y, time_step, output ready);
endinterface

// File: design/pge_out_if.sv
interface pge_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, centre_x, centre_y,
                  rect_x, rect_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, centre_x, centre_y,
                rect_x, rect_y, output ready);
endinterface

// File: design/pge_ctrl.sv
module pge_ctrl
  import pge_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam int DV_STEPS = FRAC_BITS + 1;
  localparam int LD_STEPS = FRAC_BITS + 25 + 2 * FRAC_BITS;
  localparam int SQ_STEPS = 32;
  localparam int CW = $clog2(LD_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_VX, S_VY, S_SPD, S_SQI, S_SQ, S_DVI, S_DV,
    S_MS, S_LDI, S_LD, S_ACC, S_AVX, S_AVY, S_VYU, S_PX, S_PY, S_PYU, S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          axis;
  logic          commit;

  assign in_ready = (state == S_IDLE);
  assign commit = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    cmd.act = ACT_NONE;
    cmd.msel = MUL_NONE;
    cmd.axis = axis;
    unique case (state)
      S_IDLE: if (in_valid) cmd.act = ACT_LOAD;
      S_SQX:  cmd.msel = MUL_MX2;
      S_SQY: begin
        cmd.msel = MUL_MY2;
        cmd.act = ACT_D2_SET;
      end
      S_VX: begin
        cmd.msel = MUL_VX2;
        cmd.act = ACT_D2_ADD;
      end
      S_VY: begin
        cmd.msel = MUL_VY2;
        cmd.act = ACT_SPD_SET;
      end
      S_SPD:  cmd.act = ACT_SPD_ADD;
      S_SQI:  cmd.act = ACT_SQ_INIT;
      S_SQ:   cmd.act = ACT_SQ_STEP;
      S_DVI:  cmd.act = ACT_DV_INIT;
      S_DV:   cmd.act = ACT_DV_STEP;
      S_MS:   cmd.msel = MUL_DIR_STR;
      S_LDI:  cmd.act = ACT_LD_INIT;
      S_LD:   cmd.act = ACT_LD_STEP;
      S_ACC:  cmd.act = ACT_ACC_SAVE;
      S_AVX:  cmd.msel = MUL_AX_DT;
      S_AVY: begin
        cmd.msel = MUL_AY_DT;
        cmd.act = ACT_VX_UPD;
      end
      S_VYU:  cmd.act = ACT_VY_UPD;
      S_PX:   cmd.msel = MUL_VX_DT;
      S_PY: begin
        cmd.msel = MUL_VY_DT;
        cmd.act = ACT_PX_UPD;
      end
      S_PYU:  cmd.act = ACT_PY_UPD;
      S_DONE: if (commit) cmd.act = ACT_COMMIT;
      default: cmd.act = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      axis <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_VX;
        S_VX:   state <= S_VY;
        S_VY:   state <= S_SPD;
        S_SPD:  state <= status.d2_zero ? S_AVX : S_SQI;
        S_SQI: begin
          cnt <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(SQ_STEPS - 1)) begin
            axis <= 1'b0;
            state <= S_DVI;
          end
        end
        S_DVI: begin
          cnt <= '0;
          state <= S_DV;
        end
        S_DV: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DV_STEPS - 1)) state <= S_MS;
        end
        S_MS:   state <= S_LDI;
        S_LDI: begin
          cnt <= '0;
          state <= S_LD;
        end
        S_LD: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(LD_STEPS - 1)) state <= S_ACC;
        end
        S_ACC: begin
          if (!axis) begin
            axis <= 1'b1;
            state <= S_DVI;
          end else begin
            state <= S_AVX;
          end
        end
        S_AVX:  state <= S_AVY;
        S_AVY:  state <= S_VYU;
        S_VYU:  state <= S_PX;
        S_PX:   state <= S_PY;
        S_PY:   state <= S_PYU;
        S_PYU:  state <= S_DONE;
        S_DONE: if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/pge_dp.sv
module pge_dp
  import pge_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] attractor_x,
  input  logic signed [31:0] attractor_y,
  input  logic [15:0]        time_step,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] centre_x,
  output logic signed [31:0] centre_y,
  output logic signed [15:0] rect_x,
  output logic signed [15:0] rect_y
);

  localparam int DIR_W = FRAC_BITS + 1;
  localparam int NUM_W = DIR_W + 24;
  localparam int LD_W = NUM_W + 2 * FRAC_BITS;
  localparam int XW = 12 + FRAC_BITS + 2;

  logic [23:0] strength;
  logic [7:0]  radius;
  logic [11:0] scr_w;
  logic [11:0] scr_h;
  logic [31:0] rest;

  logic signed [31:0] body_pos_x, body_pos_y, body_vel_x, body_vel_y;
  logic signed [31:0] body_centre_x, body_centre_y;

  logic signed [31:0] dx, dy, ax, ay, nvx, nvy, npx, npy;
  logic [15:0] dt;
  logic [31:0] mx, my;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, d2, spd;
  logic        slow;

  logic [63:0] sq_src;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [35:0] sq_trial, sq_cand;

  logic [32:0]      dv_rem, dv_diff;
  logic [DIR_W-1:0] dv_q;
  logic             dv_ge;

  logic [LD_W-1:0] ld_src;
  logic [63:0]     ld_rem;
  logic [64:0]     ld_trial;
  logic [31:0]     ld_q, acc_mag;
  logic            ld_ovf, ld_ge;

  logic [31:0] inc;
  logic signed [XW-1:0] rad, scr_wq, scr_hq;
  logic signed [39:0] rad_e, wlim, px_e, py_e;
  logic signed [31:0] cx, cy, wx, wy;
  logic [31:0] ipx, ipy;
  logic signed [15:0] rx, ry;

  assign mx = mag32(dx);
  assign my = mag32(dy);
  assign status.d2_zero = (d2 == 64'd0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.msel)
      MUL_MX2: begin mul_a = mx; mul_b = mx; end
      MUL_MY2: begin mul_a = my; mul_b = my; end
      MUL_VX2: begin mul_a = mag32(body_vel_x); mul_b = mag32(body_vel_x); end
      MUL_VY2: begin mul_a = mag32(body_vel_y); mul_b = mag32(body_vel_y); end
      MUL_DIR_STR: begin mul_a = 32'(dv_q); mul_b = {8'd0, strength}; end
      MUL_AX_DT: begin mul_a = mag32(ax); mul_b = {16'd0, dt}; end
      MUL_AY_DT: begin mul_a = mag32(ay); mul_b = {16'd0, dt}; end
      MUL_VX_DT: begin mul_a = mag32(nvx); mul_b = {16'd0, dt}; end
      MUL_VY_DT: begin mul_a = mag32(nvy); mul_b = {16'd0, dt}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Square root, two radicand bits per step.
  assign sq_trial = {sq_rem, sq_src[63:62]};
  assign sq_cand = {2'b00, sq_root, 2'b01};

  // Direction = (|d| << F) / root, one quotient bit per step.
  assign dv_ge = dv_rem >= {1'b0, sq_root};
  assign dv_diff = dv_rem - {1'b0, sq_root};

  // Acceleration long division by d2, quotient saturates past 31 bits.
  assign ld_trial = {ld_rem, ld_src[LD_W-1]};
  assign ld_ge = ld_trial >= {1'b0, d2};
  assign acc_mag = (ld_ovf || ld_q[31]) ? MAG_MAX : ld_q;

  assign inc = mul_p[47:16];

  // Finishing logic: centre, draw rectangle and screen wrap.
  assign rad = XW'(radius) << FRAC_BITS;
  assign scr_wq = XW'(scr_w) << FRAC_BITS;
  assign scr_hq = XW'(scr_h) << FRAC_BITS;
  assign rad_e = 40'(rad);
  assign wlim = 40'(scr_wq) - rad_e;
  assign cx = sat32(40'(npx) + rad_e);
  assign cy = sat32(40'(npy) + rad_e);
  assign ipx = mag32(npx) >> FRAC_BITS;
  assign ipy = mag32(npy) >> FRAC_BITS;

  always_comb begin
    if (npx[31]) rx = (ipx > 32'd32768) ? -16'sd32768 : 16'(-ipx);
    else rx = (ipx > 32'd32767) ? 16'sd32767 : 16'(ipx);
    if (npy[31]) ry = (ipy > 32'd32768) ? -16'sd32768 : 16'(-ipy);
    else ry = (ipy > 32'd32767) ? 16'sd32767 : 16'(ipy);
  end

  always_comb begin
    px_e = 40'(npx);
    if (px_e > wlim) px_e = '0;
    if (px_e < 0) px_e = 40'(sat32(wlim));
    py_e = 40'(npy);
    if (py_e > 40'(scr_hq)) py_e = 40'(sat32(rad_e));
    if (py_e < 0) py_e = 40'(sat32(40'(scr_hq) - rad_e));
    wx = px_e[31:0];
    wy = py_e[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= 24'd2000000;
      radius <= 8'd32;
      scr_w <= 12'd1280;
      scr_h <= 12'd720;
      rest <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STRENGTH: strength <= cfg_data[23:0];
        REG_RADIUS:   radius <= cfg_data[7:0];
        REG_WIDTH:    scr_w <= cfg_data[11:0];
        REG_HEIGHT:   scr_h <= cfg_data[11:0];
        REG_REST:     rest <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_pos_x <= '0;
      body_pos_y <= '0;
      body_vel_x <= '0;
      body_vel_y <= '0;
      body_centre_x <= '0;
      body_centre_y <= '0;
    end else if (cmd.act == ACT_COMMIT) begin
      body_pos_x <= wx;
      body_pos_y <= wy;
      body_vel_x <= nvx;
      body_vel_y <= nvy;
      body_centre_x <= cx;
      body_centre_y <= cy;
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (cmd.act)
      ACT_LOAD: begin
        dx <= sat32(40'(attractor_x) - 40'(body_centre_x));
        dy <= sat32(40'(attractor_y) - 40'(body_centre_y));
        dt <= time_step;
        ax <= '0;
        ay <= '0;
      end
      ACT_D2_SET:  d2 <= mul_p;
      ACT_D2_ADD:  d2 <= d2 + mul_p;
      ACT_SPD_SET: spd <= mul_p;
      ACT_SPD_ADD: slow <= (spd + mul_p) < (64'(rest) << FRAC_BITS);
      ACT_SQ_INIT: begin
        sq_src <= d2;
        sq_rem <= '0;
        sq_root <= '0;
      end
      ACT_SQ_STEP: begin
        sq_src <= sq_src << 2;
        if (sq_trial >= sq_cand) begin
          sq_rem <= 34'(sq_trial - sq_cand);
          sq_root <= {sq_root[30:0], 1'b1};
        end else begin
          sq_rem <= sq_trial[33:0];
          sq_root <= {sq_root[30:0], 1'b0};
        end
      end
      ACT_DV_INIT: begin
        dv_rem <= {1'b0, cmd.axis ? my : mx};
        dv_q <= '0;
      end
      ACT_DV_STEP: begin
        dv_q <= {dv_q[DIR_W-2:0], dv_ge};
        dv_rem <= dv_ge ? {dv_diff[31:0], 1'b0} : {dv_rem[31:0], 1'b0};
      end
      ACT_LD_INIT: begin
        ld_src <= {mul_p[NUM_W-1:0], {(2 * FRAC_BITS){1'b0}}};
        ld_rem <= '0;
        ld_q <= '0;
        ld_ovf <= 1'b0;
      end
      ACT_LD_STEP: begin
        ld_src <= ld_src << 1;
        ld_rem <= ld_ge ? 64'(ld_trial - {1'b0, d2}) : ld_trial[63:0];
        ld_q <= {ld_q[30:0], ld_ge};
        ld_ovf <= ld_ovf | ld_q[31];
      end
      ACT_ACC_SAVE: begin
        if (cmd.axis) ay <= dy[31] ? -$signed(acc_mag) : $signed(acc_mag);
        else ax <= dx[31] ? -$signed(acc_mag) : $signed(acc_mag);
      end
      ACT_VX_UPD:
        nvx <= sat32((slow ? 40'sd0 : 40'(body_vel_x)) + with_sign(inc, ax[31]));
      ACT_VY_UPD:
        nvy <= sat32((slow ? 40'sd0 : 40'(body_vel_y)) + with_sign(inc, ay[31]));
      ACT_PX_UPD: npx <= sat32(40'(body_pos_x) + with_sign(inc, nvx[31]));
      ACT_PY_UPD: npy <= sat32(40'(body_pos_y) + with_sign(inc, nvy[31]));
      ACT_COMMIT: begin
        pos_x <= wx;
        pos_y <= wy;
        vel_x <= nvx;
        vel_y <= nvy;
        centre_x <= cx;
        centre_y <= cy;
        rect_x <= rx;
        rect_y <= ry;
      end
      default: ;
    endcase
  end

endmodule

// File: design/point_gravity_euler_step_top.sv
// One body under inverse-square attraction, stepped with semi-implicit Euler
// per input transaction. Items are processed one at a time. Each tick runs a
// 32-step square root once, and the bit-serial direction (F + 1 steps) and
// acceleration (3*F + 25 steps) dividers, for F fractional bits, once for x
// and once for y. A tick whose attractor sits on the body centre skips them.
// One 32x32 multiplier is shared by all products. A finished result
// waits in the output register while the next transaction is accepted.
module point_gravity_euler_step_top
  import pge_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pge_in_if.sink      in_ch,
  pge_out_if.source   out_ch
);

`include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  pge_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  pge_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .attractor_x (in_ch.attractor_x),
    .attractor_y (in_ch.attractor_y),
    .time_step   (in_ch.time_step),
    .cmd         (cmd),
    .status      (status),
    .pos_x       (out_ch.pos_x),
    .pos_y       (out_ch.pos_y),
    .vel_x       (out_ch.vel_x),
    .vel_y       (out_ch.vel_y),
    .centre_x    (out_ch.centre_x),
    .centre_y    (out_ch.centre_y),
    .rect_x      (out_ch.rect_x),
    .rect_y      (out_ch.rect_y)
  );

  `ASSERT_IMPLIES(a_commit_free, clk, rst, cmd.act == ACT_COMMIT, !out_ch.valid || out_ch.ready, "result overwritten before it was taken")
  `ASSERT_IMPLIES(a_load_on_accept, clk, rst, cmd.act == ACT_LOAD, in_ch.valid && in_ch.ready, "operands loaded without a transaction")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready, "second transaction taken while busy")
  `ASSERT_NEXT(a_commit_sets_valid, clk, rst, cmd.act == ACT_COMMIT, out_ch.valid, "result not presented after commit")

endmodule

// File: bench/point_gravity_euler_step_top_tb.sv
typedef struct {
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
} body_state_t;

class body_tracker;
  localparam int F = 16;
  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;

  longint unsigned strength, radius, width, height, rest_sq;
  longint px, py, vx, vy, cx, cy;
  body_state_t awaited[$];
  int mismatches;

  function new();
    strength = 2000000;
    radius = 32;
    width = 1280;
    height = 720;
    rest_sq = 65536;
    px = 0; py = 0; vx = 0; vy = 0; cx = 0; cy = 0;
    mismatches = 0;
  endfunction

  function void configure(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pge_pkg::REG_STRENGTH: strength = data[23:0];
      pge_pkg::REG_RADIUS:   radius = data[7:0];
      pge_pkg::REG_WIDTH:    width = data[11:0];
      pge_pkg::REG_HEIGHT:   height = data[11:0];
      pge_pkg::REG_REST:     rest_sq = data;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint v);
    if (v > HI32) return HI32;
    if (v < LO32) return LO32;
    return v;
  endfunction

  function longint unsigned absval(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function longint apply_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Long division of (num << sh) by den, bit by bit, stopping at the cap.
  function longint unsigned shifted_quotient(longint unsigned num, int sh,
                                             longint unsigned den, longint unsigned cap);
    longint unsigned q, r, r2;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int i = 0; i < sh; i++) begin
      r2 = r << 1;
      q <<= 1;
      if (r2 >= den) begin
        q |= 1;
        r2 -= den;
      end
      r = r2;
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function longint scale_dt(longint v, longint unsigned dt);
    return apply_sign((absval(v) * dt) >> 16, v < 0);
  endfunction

  function longint pull(longint d, longint unsigned root_len, longint unsigned dist2);
    longint unsigned dir;
    dir = (absval(d) << F) / root_len;
    return apply_sign(shifted_quotient(dir * strength, 2 * F, dist2, HI32), d < 0);
  endfunction

  function logic [15:0] rect_of(longint p);
    longint r;
    r = apply_sign(absval(p) >> F, p < 0);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function void note_tick(logic signed [31:0] att_x, logic signed [31:0] att_y,
                          logic [15:0] dt);
    longint dx, dy, ax, ay, rad, w, h, nx, ny;
    longint unsigned mx, my, d2, root_len, sx, sy;
    body_state_t e;
    dx = clamp32(longint'(att_x) - cx);
    dy = clamp32(longint'(att_y) - cy);
    mx = absval(dx);
    my = absval(dy);
    d2 = mx * mx + my * my;
    ax = 0;
    ay = 0;
    rad = radius << F;
    w = width << F;
    h = height << F;
    if (d2 != 0) begin
      root_len = int_sqrt(d2);
      ax = pull(dx, root_len, d2);
      ay = pull(dy, root_len, d2);
    end
    sx = absval(vx);
    sy = absval(vy);
    if (sx * sx + sy * sy < (rest_sq << F)) begin
      vx = 0;
      vy = 0;
    end
    vx = clamp32(vx + scale_dt(ax, dt));
    vy = clamp32(vy + scale_dt(ay, dt));
    px = clamp32(px + scale_dt(vx, dt));
    py = clamp32(py + scale_dt(vy, dt));
    cx = clamp32(px + rad);
    cy = clamp32(py + rad);
    e.rect_x = rect_of(px);
    e.rect_y = rect_of(py);
    nx = px;
    ny = py;
    if (nx > w - rad) nx = 0;
    if (nx < 0) nx = clamp32(w - rad);
    if (ny > h) ny = clamp32(rad);
    if (ny < 0) ny = clamp32(h - rad);
    px = nx;
    py = ny;
    e.pos_x = px[31:0];
    e.pos_y = py[31:0];
    e.vel_x = vx[31:0];
    e.vel_y = vy[31:0];
    e.centre_x = cx[31:0];
    e.centre_y = cy[31:0];
    awaited.push_back(e);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, $signed(want), $signed(got));
    end
  endfunction

  function void check_result(body_state_t got);
    body_state_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result transaction with no tick pending");
      return;
    end
    e = awaited.pop_front();
    compare_field("pos_x", e.pos_x, got.pos_x);
    compare_field("pos_y", e.pos_y, got.pos_y);
    compare_field("vel_x", e.vel_x, got.vel_x);
    compare_field("vel_y", e.vel_y, got.vel_y);
    compare_field("centre_x", e.centre_x, got.centre_x);
    compare_field("centre_y", e.centre_y, got.centre_y);
    compare_field("rect_x", {{16{e.rect_x[15]}}, e.rect_x}, {{16{got.rect_x[15]}}, got.rect_x});
    compare_field("rect_y", {{16{e.rect_y[15]}}, e.rect_y}, {{16{got.rect_y[15]}}, got.rect_y});
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module point_gravity_euler_step_top_tb;
  import pge_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pge_in_if  in_ch ();
  pge_out_if out_ch ();

  point_gravity_euler_step_top dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  body_tracker tracker;
  bit idling_on;
  bit hold_request;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    body_state_t got;
    if (!rst && in_ch.valid && in_ch.ready)
      tracker.note_tick(in_ch.attractor_x, in_ch.attractor_y, in_ch.time_step);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.pos_x = out_ch.pos_x;
      got.pos_y = out_ch.pos_y;
      got.vel_x = out_ch.vel_x;
      got.vel_y = out_ch.vel_y;
      got.centre_x = out_ch.centre_x;
      got.centre_y = out_ch.centre_y;
      got.rect_x = out_ch.rect_x;
      got.rect_y = out_ch.rect_y;
      tracker.check_result(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        for (n = 0; n < 3000; n++) @(negedge clk);
        hold_request = 1'b0;
        out_ch.ready = 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_tick(logic signed [31:0] att_x, logic signed [31:0] att_y,
                           logic [15:0] dt);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.attractor_x = att_x;
    in_ch.attractor_y = att_y;
    in_ch.time_step = dt;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    // The output register may still be settling after the last transaction.
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    tracker.configure(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_all(logic [31:0] s, logic [31:0] r, logic [31:0] w,
                         logic [31:0] h, logic [31:0] q);
    write_reg(REG_STRENGTH, s);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_REST, q);
  endtask

  // Mostly attractors somewhere on the screen with short frame times, so the
  // body actually orbits and wraps; some sit on the body centre, the rest is full-range noise.
  task automatic random_ticks(int count);
    logic signed [31:0] ax, ay;
    logic [15:0] dt;
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        ax = $signed($urandom_range(0, 1400) << 16) + $signed($urandom_range(0, 65535));
        ay = $signed($urandom_range(0, 800) << 16) + $signed($urandom_range(0, 65535));
        dt = 16'($urandom_range(0, 4000));
      end else if (kind < 80) begin
        ax = tracker.cx[31:0];
        ay = tracker.cy[31:0];
        dt = 16'($urandom_range(0, 65535));
      end else begin
        ax = $urandom;
        ay = $urandom;
        dt = 16'($urandom);
      end
      send_tick(ax, ay, dt);
    end
  endtask

  initial begin
    tracker = new();
    idling_on = 1'b1;
    hold_request = 1'b0;
    cycle_count = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_STRENGTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.attractor_x = '0;
    in_ch.attractor_y = '0;
    in_ch.time_step = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: the attractor on the body centre, the field extremes, both
    // ends of the time step and differences too large for 32 bits.
    send_tick(32'sd0, 32'sd0, 16'hffff);
    send_tick(tracker.cx[31:0], tracker.cy[31:0], 16'h1000);
    send_tick(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    send_tick(32'sh80000000, 32'sh80000000, 16'hffff);
    send_tick(32'sh7fffffff, 32'sh80000000, 16'h0000);
    send_tick(32'sh80000000, 32'sh7fffffff, 16'h8000);
    send_tick(32'sd0, 32'sh7fffffff, 16'h0001);
    send_tick(32'sh80000000, 32'sd0, 16'hffff);
    send_tick(32'sd640 <<< 16, 32'sd360 <<< 16, 16'h0444);
    send_tick(32'sd640 <<< 16, 32'sd360 <<< 16, 16'h0444);
    send_tick(32'sd1 <<< 16, -(32'sd1 <<< 16), 16'hffff);
    send_tick(tracker.cx[31:0], tracker.cy[31:0], 16'hffff);
    send_tick(32'sd1300 <<< 16, 32'sd800 <<< 16, 16'h7fff);
    send_tick(-(32'sd50 <<< 16), -(32'sd50 <<< 16), 16'hffff);
    send_tick(32'sd0, 32'sd0, 16'h0000);
    drain();

    set_all(32'hffffff, 32'd255, 32'd1, 32'd1, 32'd0);
    send_tick(32'sh7fffffff, 32'sh80000000, 16'hffff);
    send_tick(32'sd10 <<< 16, 32'sd10 <<< 16, 16'h8000);
    random_ticks(250);
    drain();

    set_all(32'd0, 32'd0, 32'd4095, 32'd4095, 32'hffffffff);
    random_ticks(150);
    drain();

    set_all(2000000, 32, 1280, 720, 65536);
    random_ticks(150);
    // Hold the receiver off while offering transactions so the block backs up.
    hold_request = 1'b1;
    random_ticks(20);
    drain();

    set_all($urandom_range(0, 24'hffffff), $urandom_range(0, 255),
            $urandom_range(1, 4095), $urandom_range(1, 4095), $urandom);
    random_ticks(300);
    drain();

    set_all(500000, 16, 1280, 720, 32'd4096);
    random_ticks(450);
    idling_on = 1'b0;
    random_ticks(250);
    drain();

    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
